// ----- design/swil_pkg.sv -----
`default_nettype none

package swil_pkg;

    // Default number of cells in the chain.
    localparam int LIST_DEPTH_DEF = 32;

    localparam int SYM_W = 8;
    localparam int WT_W  = 16;

    // Command codes carried on the input tuser bit.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    // One stored list entry.
    typedef struct packed {
        logic [WT_W-1:0]  wt;
        logic [SYM_W-1:0] sym;
    } entry_t;

    // Operation broadcast from the controller to every cell.
    typedef struct packed {
        logic   insert;
        logic   rotate;
        entry_t new_entry;
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage

`default_nettype wire

// ----- design/swil_cell.sv -----
`default_nettype none

module swil_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire swil_pkg::op_t     op,
    input  wire swil_pkg::entry_t  prev_data,
    input  wire logic              prev_valid,
    input  wire logic              prev_ge,
    input  wire swil_pkg::entry_t  next_data,
    input  wire logic              next_valid,
    input  wire swil_pkg::entry_t  head_data,
    output swil_pkg::entry_t       data,
    output logic                   valid,
    output logic                   ge
);
    import swil_pkg::*;

    entry_t data_reg;
    entry_t data_next;
    logic   valid_reg;
    logic   valid_next;
    logic   is_tail;

    // An empty cell or one holding a weight at or above the new one yields its place.
    assign ge      = !valid_reg || (data_reg.wt >= op.new_entry.wt);
    assign is_tail = valid_reg && !next_valid;

    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (op.insert) begin
            // Shift right behind the insertion point, load the new entry at it.
            if (prev_ge) begin
                data_next = prev_data;
            end else if (ge) begin
                data_next = op.new_entry;
            end
            valid_next = valid_reg | prev_valid;
        end else if (op.rotate) begin
            // Rotate the occupied part of the chain toward the head.
            data_next = is_tail ? head_data : next_data;
        end
    end

    // Entry payload needs no reset.
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ----- design/swil_ctrl.sv -----
`default_nettype none

module swil_ctrl #(
    parameter int LIST_DEPTH = swil_pkg::LIST_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [23:0]       s_tdata,
    input  wire logic              s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [23:0]            m_tdata,
    output logic                   m_tlast,
    output logic [1:0]             m_tuser,
    input  wire swil_pkg::entry_t  head_data,
    output swil_pkg::op_t          op
);
    import swil_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic          ovf_reg, ovf_next;
    logic          mvalid_reg, mvalid_next;
    entry_t        mdata_reg, mdata_next;
    logic          mlast_reg, mlast_next;
    logic          mempty_reg, mempty_next;
    logic          movf_reg, movf_next;

    logic          in_xfer;
    logic          full;
    logic          slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign full      = (count_reg == CW'(LIST_DEPTH));
    assign slot_free = !mvalid_reg || m_tready;

    // Next state, list bookkeeping and output stage loading.
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        remain_next      = remain_reg;
        ovf_next         = ovf_reg;
        mvalid_next      = mvalid_reg && !m_tready;
        mdata_next       = mdata_reg;
        mlast_next       = mlast_reg;
        mempty_next      = mempty_reg;
        movf_next        = movf_reg;
        op.insert        = 1'b0;
        op.rotate        = 1'b0;
        op.new_entry.sym = s_tdata[7:0];
        op.new_entry.wt  = s_tdata[23:8];

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == CMD_DUMP) begin
                        remain_next = count_reg;
                        state_next  = ST_DUMP;
                    end else if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        op.insert  = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ST_DUMP: begin
                if (slot_free) begin
                    mvalid_next = 1'b1;
                    movf_next   = ovf_reg;
                    if (count_reg == '0) begin
                        mdata_next  = '0;
                        mlast_next  = 1'b1;
                        mempty_next = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        // Emit the head and rotate it to the tail of the list.
                        mdata_next  = head_data;
                        mlast_next  = (remain_reg == CW'(1));
                        mempty_next = 1'b0;
                        op.rotate   = 1'b1;
                        remain_next = remain_reg - CW'(1);
                        if (remain_reg == CW'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Output payload and dump counter carry no reset.
    always_ff @(posedge aclk) begin
        remain_reg <= remain_next;
        mdata_reg  <= mdata_next;
        mlast_reg  <= mlast_next;
        mempty_reg <= mempty_next;
        movf_reg   <= movf_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {mdata_reg.wt, mdata_reg.sym};
    assign m_tlast  = mlast_reg;
    assign m_tuser  = {movf_reg, mempty_reg};

endmodule

`default_nettype wire

// ----- design/sorted_weight_insert_list.sv -----
// Insert: one transfer per cycle while idle, back to back; the entry sits in the chain from the
// next cycle (a full list drops it and sets the overflow flag). Dump: results leave at one per
// cycle while m_tready is high; each entry rotates through cell 0 and back to the tail.
// s_tready stays low from the dump command until its last result enters the output stage.
// Reset (aresetn low, synchronous) clears cell valid bits, entry count, overflow flag, output valid, state.
`default_nettype none

module sorted_weight_insert_list #(
    parameter int LIST_DEPTH = swil_pkg::LIST_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] symbol, [23:8] weight
    input  wire logic        s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_symbol, [23:8] out_weight
    output logic             m_tlast,
    output logic [1:0]       m_tuser    // [0] empty_res, [1] overflow
);
    import swil_pkg::*;

    op_t                   op;
    entry_t                cell_data [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_valid;
    logic [LIST_DEPTH-1:0] cell_ge;

    swil_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .head_data (cell_data[0]),
        .op        (op)
    );

    // Chain of cells, cell 0 holds the smallest weight.
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        entry_t prev_data;
        logic   prev_valid;
        logic   prev_ge;
        entry_t next_data;
        logic   next_valid;

        if (i == 0) begin : g_first
            assign prev_data  = '0;
            assign prev_valid = 1'b1;
            assign prev_ge    = 1'b0;
        end else begin : g_mid
            assign prev_data  = cell_data[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_ge    = cell_ge[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_last
            assign next_data  = '0;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_data  = cell_data[i+1];
            assign next_valid = cell_valid[i+1];
        end

        swil_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .prev_data  (prev_data),
            .prev_valid (prev_valid),
            .prev_ge    (prev_ge),
            .next_data  (next_data),
            .next_valid (next_valid),
            .head_data  (cell_data[0]),
            .data       (cell_data[i]),
            .valid      (cell_valid[i]),
            .ge         (cell_ge[i])
        );
    end

endmodule

`default_nettype wire

// ----- design/swil_check.sv -----
`default_nettype none

module swil_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);
    import swil_pkg::*;

    // A result flagged empty is the only result of its dump.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("empty dump result without tlast");

    // An empty result carries zero symbol and weight.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 24'd0))
        else $error("empty dump result with nonzero data");

    // A dump command closes the input until its results are produced.
    a_dump_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_DUMP)) |=> !s_tready)
        else $error("input accepted right after a dump command");

    // The overflow flag never clears once shown.
    a_ovf_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && $past(aresetn) && $past(m_tvalid && m_tuser[1])) |-> m_tuser[1])
        else $error("overflow flag cleared without reset");

    // A held result keeps its payload while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind sorted_weight_insert_list swil_check u_swil_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
